// ===== src/tsr_pkg.sv =====
// Package for the track slip ratio block: field widths, stage count,
// register indexes and the types shared by the pipeline modules.
// No dependencies.
`default_nettype none
package tsr_pkg;

	localparam int IN_W      = 24;          // speed and rate fields, signed Q.16
	localparam int CFG_W     = 18;          // configuration registers
	localparam int SLIP_W    = 16;          // slip outputs, signed Q2.14
	localparam int CMD_SHIFT = 17;          // Q.16 speed to 2^-33 m/s units
	localparam int CMD_W     = 43;          // commanded speed, 2^-33 m/s
	localparam int DIFF_W    = 44;          // commanded minus measured
	localparam int MAG_W     = 43;          // divisor and remainder magnitude
	localparam int QUO_W     = 15;          // quotient bits kept before clamping
	localparam int DIV_STEPS = QUO_W - 1;   // one quotient bit per stage after the first
	localparam int NUM_STAGES = 6 + DIV_STEPS;

	localparam int IDX_W = 1;
	localparam logic [IDX_W-1:0] REG_GAUGE           = 1'd0;
	localparam logic [IDX_W-1:0] REG_SPEED_THRESHOLD = 1'd1;

	localparam logic [CFG_W-1:0] GAUGE_RST           = 18'd36045;
	localparam logic [CFG_W-1:0] SPEED_THRESHOLD_RST = 18'd3277;

	localparam logic signed [SLIP_W-1:0] SLIP_MAX = 16'sd16384;
	localparam logic signed [SLIP_W-1:0] SLIP_MIN = -16'sd8192;
	localparam logic [QUO_W-1:0] QUO_POS_LIM = 15'd16384;
	localparam logic [QUO_W-1:0] QUO_NEG_LIM = 15'd8192;

	// Long-division state of one side
	typedef struct packed {
		logic [MAG_W-1:0] rem;
		logic [MAG_W-1:0] mag;
		logic [QUO_W-1:0] quo;
		logic             neg;
		logic             zero;
		logic             ovf;
	} div_t;

	typedef struct packed {
		logic adv;
		logic skid_full;
	} flow_stat_t;

endpackage
`default_nettype wire

// ===== src/track_slip_ratio.sv =====
// Track slip ratio for a tracked drive: from body speed and yaw rate it
// forms commanded track speeds v -+ w*W/2 and gives per side the slip
// 1 - measured/commanded in Q2.14, clamped to -0.5..1.0, zero where the
// commanded magnitude is at or below speed_threshold. One item per cycle
// is taken while the skid register is empty; results pass the front,
// difference, magnitude, 15-stage division and clamp registers. When
// the output register holds a result that m_tready does not take, the
// next result parks in a skid register and s_tready stays low until that
// result has moved on to the output register. Registers must be written
// through the cfg port only while no item is in flight; the block does
// not enforce this. Depends on tsr_pkg, tsr_front, tsr_side, tsr_flow.
`default_nettype none
module track_slip_ratio (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          s_tvalid,
	output logic                               s_tready,
	// body_speed[23:0], yaw_rate[47:24], left_measured[71:48], right_measured[95:72]
	input  wire logic [4*tsr_pkg::IN_W-1:0]    s_tdata,
	output logic                               m_tvalid,
	input  wire logic                          m_tready,
	// left_slip[15:0], right_slip[31:16]
	output logic [2*tsr_pkg::SLIP_W-1:0]       m_tdata,
	input  wire logic                          cfg_we,
	input  wire logic [tsr_pkg::IDX_W-1:0]     cfg_idx,
	input  wire logic [tsr_pkg::CFG_W-1:0]     cfg_data
);
	import tsr_pkg::*;

	logic [CFG_W-1:0]         width_q;
	logic [CFG_W-1:0]         thr_q;
	flow_stat_t               stat;
	logic signed [CMD_W-1:0]  cmd_left, cmd_right;
	logic signed [IN_W-1:0]   meas_left, meas_right;
	logic signed [SLIP_W-1:0] left_slip, right_slip;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_q <= GAUGE_RST;
			thr_q   <= SPEED_THRESHOLD_RST;
		end else if (cfg_we) begin
			case (cfg_idx)
				REG_GAUGE:           width_q <= cfg_data;
				REG_SPEED_THRESHOLD: thr_q   <= cfg_data;
				default: ;
			endcase
		end
	end

	tsr_front u_front (
		.clk            (clk),
		.adv            (stat.adv),
		.gauge          (width_q),
		.body_speed     ($signed(s_tdata[IN_W-1:0])),
		.yaw_rate       ($signed(s_tdata[2*IN_W-1:IN_W])),
		.left_measured  ($signed(s_tdata[3*IN_W-1:2*IN_W])),
		.right_measured ($signed(s_tdata[4*IN_W-1:3*IN_W])),
		.cmd_left       (cmd_left),
		.cmd_right      (cmd_right),
		.meas_left      (meas_left),
		.meas_right     (meas_right)
	);

	tsr_side u_left (
		.clk             (clk),
		.adv             (stat.adv),
		.speed_threshold (thr_q),
		.cmd             (cmd_left),
		.meas            (meas_left),
		.slip            (left_slip)
	);

	tsr_side u_right (
		.clk             (clk),
		.adv             (stat.adv),
		.speed_threshold (thr_q),
		.cmd             (cmd_right),
		.meas            (meas_right),
		.slip            (right_slip)
	);

	tsr_flow u_flow (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (s_tvalid),
		.out_ready (m_tready),
		.res       ({right_slip, left_slip}),
		.stat      (stat),
		.out_valid (m_tvalid),
		.out_data  (m_tdata)
	);

	assign s_tready = stat.adv;

`ifndef NO_ASSERTIONS
	a_skid_behind_out: assert property (@(posedge clk) disable iff (!arst_n)
		stat.skid_full |-> m_tvalid)
		else $error("skid register holds a result while the output is empty");

	a_stall_cause: assert property (@(posedge clk) disable iff (!arst_n)
		!s_tready |-> (m_tvalid && $past(m_tvalid)))
		else $error("input stalled without a waiting result");

	a_left_range: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> ($signed(m_tdata[SLIP_W-1:0]) >= SLIP_MIN &&
			$signed(m_tdata[SLIP_W-1:0]) <= SLIP_MAX))
		else $error("left slip outside clamp range");

	a_right_range: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> ($signed(m_tdata[2*SLIP_W-1:SLIP_W]) >= SLIP_MIN &&
			$signed(m_tdata[2*SLIP_W-1:SLIP_W]) <= SLIP_MAX))
		else $error("right slip outside clamp range");
`endif

endmodule
`default_nettype wire

// ===== src/tsr_front.sv =====
// Front stages of the track slip ratio pipeline: yaw times track width,
// then commanded left and right track speeds. Uses tsr_pkg.
`default_nettype none
module tsr_front (
	input  wire logic                               clk,
	input  wire logic                               adv,
	input  wire logic [tsr_pkg::CFG_W-1:0]          gauge,
	input  wire logic signed [tsr_pkg::IN_W-1:0]    body_speed,
	input  wire logic signed [tsr_pkg::IN_W-1:0]    yaw_rate,
	input  wire logic signed [tsr_pkg::IN_W-1:0]    left_measured,
	input  wire logic signed [tsr_pkg::IN_W-1:0]    right_measured,
	output logic signed [tsr_pkg::CMD_W-1:0]        cmd_left,
	output logic signed [tsr_pkg::CMD_W-1:0]        cmd_right,
	output logic signed [tsr_pkg::IN_W-1:0]         meas_left,
	output logic signed [tsr_pkg::IN_W-1:0]         meas_right
);
	import tsr_pkg::*;

	logic signed [CMD_W-1:0] speed_s1;
	logic signed [CMD_W-1:0] turn_s1;
	logic signed [IN_W-1:0]  ml_s1, mr_s1;
	logic signed [CMD_W-1:0] cl_s2, cr_s2;
	logic signed [IN_W-1:0]  ml_s2, mr_s2;

	always_ff @(posedge clk) begin
		if (adv) begin
			speed_s1 <= {{(CMD_W-IN_W-CMD_SHIFT){body_speed[IN_W-1]}}, body_speed,
				{CMD_SHIFT{1'b0}}};
			turn_s1  <= CMD_W'(yaw_rate) * CMD_W'($signed({1'b0, gauge}));
			ml_s1    <= left_measured;
			mr_s1    <= right_measured;
			cl_s2    <= speed_s1 - turn_s1;
			cr_s2    <= speed_s1 + turn_s1;
			ml_s2    <= ml_s1;
			mr_s2    <= mr_s1;
		end
	end

	assign cmd_left   = cl_s2;
	assign cmd_right  = cr_s2;
	assign meas_left  = ml_s2;
	assign meas_right = mr_s2;

endmodule
`default_nettype wire

// ===== src/tsr_div_stage.sv =====
// One restoring long-division stage: doubles the remainder, subtracts the
// divisor when it fits and shifts in one quotient bit. Uses tsr_pkg.
`default_nettype none
module tsr_div_stage (
	input  wire logic          clk,
	input  wire logic          adv,
	input  wire tsr_pkg::div_t din,
	output tsr_pkg::div_t      dout
);
	import tsr_pkg::*;

	logic [MAG_W:0]   dbl;
	logic [MAG_W:0]   diff;
	logic             fits;
	div_t             nxt;
	div_t             div_sx;

	always_comb begin
		dbl  = {din.rem, 1'b0};
		diff = dbl - {1'b0, din.mag};
		fits = dbl >= {1'b0, din.mag};
		nxt      = din;
		nxt.rem  = fits ? diff[MAG_W-1:0] : dbl[MAG_W-1:0];
		nxt.quo  = {din.quo[QUO_W-2:0], fits};
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			div_sx <= nxt;
		end
	end

	assign dout = div_sx;

endmodule
`default_nettype wire

// ===== src/tsr_side.sv =====
// Slip of one track: difference and magnitudes, threshold test, pipelined
// long division and final clamp. Uses tsr_pkg and tsr_div_stage.
`default_nettype none
module tsr_side (
	input  wire logic                               clk,
	input  wire logic                               adv,
	input  wire logic [tsr_pkg::CFG_W-1:0]          speed_threshold,
	input  wire logic signed [tsr_pkg::CMD_W-1:0]   cmd,
	input  wire logic signed [tsr_pkg::IN_W-1:0]    meas,
	output logic signed [tsr_pkg::SLIP_W-1:0]       slip
);
	import tsr_pkg::*;

	logic signed [DIFF_W-1:0] d_s3;
	logic signed [CMD_W-1:0]  c_s3;
	logic [MAG_W-1:0]         magc_s4;
	logic [DIFF_W-1:0]        magd_s4;
	logic                     neg_s4;
	div_t                     div_s5;
	logic signed [SLIP_W-1:0] slip_s20;

	logic [DIFF_W-1:0] divisor2;
	logic [DIFF_W-1:0] divisor1;
	logic [DIFF_W-1:0] first_diff;
	logic              first_bit;
	div_t              prep;
	div_t              chain [DIV_STEPS+1];
	div_t              fin;
	logic signed [SLIP_W-1:0] clamp;

	always_comb begin
		divisor2   = {magc_s4, 1'b0};
		divisor1   = {1'b0, magc_s4};
		first_diff = magd_s4 - divisor1;
		first_bit  = magd_s4 >= divisor1;
		prep.mag   = magc_s4;
		prep.neg   = neg_s4;
		// slow side: magnitude at or below threshold (covers zero command)
		prep.zero  = magc_s4 <= {{(MAG_W-CFG_W-CMD_SHIFT){1'b0}}, speed_threshold,
			{CMD_SHIFT{1'b0}}};
		// quotient of 2^15 or more clamps on either side
		prep.ovf   = magd_s4 >= divisor2;
		prep.rem   = first_bit ? first_diff[MAG_W-1:0] : magd_s4[MAG_W-1:0];
		prep.quo   = {{(QUO_W-1){1'b0}}, first_bit};
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			d_s3    <= {cmd[CMD_W-1], cmd} -
				{{(DIFF_W-IN_W-CMD_SHIFT){meas[IN_W-1]}}, meas, {CMD_SHIFT{1'b0}}};
			c_s3    <= cmd;
			magc_s4 <= c_s3[CMD_W-1] ? -c_s3 : c_s3;
			magd_s4 <= d_s3[DIFF_W-1] ? -d_s3 : d_s3;
			neg_s4  <= d_s3[DIFF_W-1] ^ c_s3[CMD_W-1];
			div_s5  <= prep;
		end
	end

	assign chain[0] = div_s5;

	for (genvar i = 0; i < DIV_STEPS; i++) begin : g_div
		tsr_div_stage u_stage (
			.clk  (clk),
			.adv  (adv),
			.din  (chain[i]),
			.dout (chain[i+1])
		);
	end

	always_comb begin
		fin = chain[DIV_STEPS];
		if (fin.zero) begin
			clamp = '0;
		end else if (fin.neg) begin
			if (fin.ovf || fin.quo > QUO_NEG_LIM) begin
				clamp = SLIP_MIN;
			end else begin
				clamp = -$signed({1'b0, fin.quo});
			end
		end else begin
			if (fin.ovf || fin.quo > QUO_POS_LIM) begin
				clamp = SLIP_MAX;
			end else begin
				clamp = $signed({1'b0, fin.quo});
			end
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			slip_s20 <= clamp;
		end
	end

	assign slip = slip_s20;

endmodule
`default_nettype wire

// ===== src/tsr_flow.sv =====
// Flow control of the track slip ratio pipeline: valid bits per stage,
// output register and skid register. Uses tsr_pkg.
`default_nettype none
module tsr_flow (
	input  wire logic                           clk,
	input  wire logic                           arst_n,
	input  wire logic                           in_valid,
	input  wire logic                           out_ready,
	input  wire logic [2*tsr_pkg::SLIP_W-1:0]   res,
	output tsr_pkg::flow_stat_t                 stat,
	output logic                                out_valid,
	output logic [2*tsr_pkg::SLIP_W-1:0]        out_data
);
	import tsr_pkg::*;

	logic [NUM_STAGES-1:0]   vld_q;
	logic                    out_v_q;
	logic [2*SLIP_W-1:0]     out_q;
	logic                    skid_v_q;
	logic [2*SLIP_W-1:0]     skid_q;
	logic                    adv;
	logic                    out_free;

	assign adv      = !skid_v_q;
	assign out_free = !out_v_q || out_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q    <= '0;
			out_v_q  <= 1'b0;
			skid_v_q <= 1'b0;
		end else begin
			if (adv) begin
				vld_q <= {vld_q[NUM_STAGES-2:0], in_valid};
			end
			if (out_free) begin
				// drain the skid first; the pipe is frozen while it is full
				out_v_q  <= skid_v_q || vld_q[NUM_STAGES-1];
				skid_v_q <= 1'b0;
			end else if (adv && vld_q[NUM_STAGES-1]) begin
				skid_v_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (out_free) begin
			out_q <= skid_v_q ? skid_q : res;
		end else if (adv) begin
			skid_q <= res;
		end
	end

	assign stat.adv       = adv;
	assign stat.skid_full = skid_v_q;
	assign out_valid      = out_v_q;
	assign out_data       = out_q;

endmodule
`default_nettype wire
